@@ design/smp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

  // Field widths.
  localparam int ModeW = 12;
  localparam int WhoW  = 9;
  localparam int CharW = 8;

  // Function codes of an input beat.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CHAR = 1'b1;

  // Pending operator codes.
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_PLUS   = 2'd1;
  localparam logic [1:0] OP_MINUS  = 2'd2;
  localparam logic [1:0] OP_EQUALS = 2'd3;

  // Clause phase codes.
  localparam logic [1:0] PH_WHO  = 2'd0;
  localparam logic [1:0] PH_OP   = 2'd1;
  localparam logic [1:0] PH_PERM = 2'd2;
  localparam logic [1:0] PH_COPY = 2'd3;

  // Status codes.
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  // Characters of the mode string.
  localparam logic [CharW-1:0] CH_ZERO  = "0";
  localparam logic [CharW-1:0] CH_SEVEN = "7";
  localparam logic [CharW-1:0] CH_PLUS  = "+";
  localparam logic [CharW-1:0] CH_MINUS = "-";
  localparam logic [CharW-1:0] CH_EQ    = "=";
  localparam logic [CharW-1:0] CH_COMMA = ",";
  localparam logic [CharW-1:0] CH_U     = "u";
  localparam logic [CharW-1:0] CH_G     = "g";
  localparam logic [CharW-1:0] CH_O     = "o";
  localparam logic [CharW-1:0] CH_A     = "a";
  localparam logic [CharW-1:0] CH_R     = "r";
  localparam logic [CharW-1:0] CH_W     = "w";
  localparam logic [CharW-1:0] CH_X     = "x";
  localparam logic [CharW-1:0] CH_T     = "t";

  // Permission masks.
  localparam logic [WhoW-1:0]  WHO_USER  = 9'o700;
  localparam logic [WhoW-1:0]  WHO_GROUP = 9'o070;
  localparam logic [WhoW-1:0]  WHO_OTHER = 9'o007;
  localparam logic [WhoW-1:0]  WHO_ALL   = 9'o777;
  localparam logic [WhoW-1:0]  READ_BITS = 9'o444;
  localparam logic [WhoW-1:0]  WRITE_BITS = 9'o222;
  localparam logic [WhoW-1:0]  EXEC_BITS = 9'o111;
  localparam logic [ModeW-1:0] STICKY_BIT = 12'o1000;

  typedef struct packed {
    logic             func;
    logic [ModeW-1:0] start_mode;
    logic [CharW-1:0] character;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [ModeW-1:0] final_mode;
    logic             status;
  } result_t;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic [ModeW-1:0] original_mode;
    logic [ModeW-1:0] working_mode;
    logic [ModeW-1:0] octal_value;
    logic             all_octal;
    logic [1:0]       clause_phase;
    logic [WhoW-1:0]  who_mask;
    logic [ModeW-1:0] work_mask;
    logic [1:0]       pending_op;
    logic             error_seen;
  } state_t;

  // Fresh string state for a given start mode.
  function automatic state_t begin_string(logic [ModeW-1:0] orig);
    state_t s;
    s.original_mode = orig;
    s.working_mode  = orig;
    s.octal_value   = '0;
    s.all_octal     = 1'b1;
    s.clause_phase  = PH_WHO;
    s.who_mask      = '0;
    s.work_mask     = '0;
    s.pending_op    = OP_NONE;
    s.error_seen    = 1'b0;
    return s;
  endfunction

  // Applies the pending operator to the working mode.
  function automatic logic [ModeW-1:0] apply_op(logic [1:0] op, logic [ModeW-1:0] wm,
                                               logic [WhoW-1:0] who,
                                               logic [ModeW-1:0] wk);
    logic [ModeW-1:0] r;
    case (op)
      OP_PLUS:   r = wm | wk;
      OP_MINUS:  r = wm & ~wk;
      OP_EQUALS: r = (wm & ~{3'b000, who}) | wk;
      default:   r = wm;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/symbolic_mode_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Symbolic mode parser: edits a 12-bit file mode with a chmod-style mode string fed one
// character per beat. A load beat (func 0) sets the start mode and opens a string; each
// character beat advances the parse, and the character marked last yields one result beat
// with the final mode and a status (error returns the start mode). The block takes one beat
// per cycle unless stalled; the whole parse step is done while a beat is in the input register,
// and its result enters the output register on the next edge. The input side stalls only
// while a result is due and the output register holds a result that is itself stalled.
module symbolic_mode_parser (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_stall,
  input  wire smp_pkg::item_t   item,
  output logic                  result_valid,
  input  wire                   result_stall,
  output smp_pkg::result_t      result
);
  import smp_pkg::*;

  item_t   beat;
  logic    beat_valid;
  state_t  st;
  state_t  st_next;
  logic    fire;
  result_t res;
  logic    out_free;
  logic    advance;

  smp_step u_step (
    .st      (st),
    .beat    (beat),
    .st_next (st_next),
    .fire    (fire),
    .res     (res)
  );

  // The held beat moves on unless it needs the output register and that is full and stalled.
  assign out_free   = !result_valid || !result_stall;
  assign advance    = beat_valid && (!fire || out_free);
  assign item_stall = beat_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!item_stall) begin
      beat_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      beat <= item;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= begin_string('0);
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && fire;
    end
    if (out_free && advance && fire) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

@@ design/smp_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one input beat.
module smp_step (
  input  wire smp_pkg::state_t  st,
  input  wire smp_pkg::item_t   beat,
  output smp_pkg::state_t       st_next,
  output logic                  fire,
  output smp_pkg::result_t      res
);
  import smp_pkg::*;

  always_comb begin
    state_t           s;
    logic [CharW-1:0] c;
    logic [1:0]       op;
    logic [WhoW-1:0]  wb;
    logic [2:0]       cls;

    s    = st;
    c    = beat.character;
    fire = 1'b0;
    res  = '0;
    cls  = '0;

    // Operator decode.
    case (c)
      CH_PLUS:  op = OP_PLUS;
      CH_MINUS: op = OP_MINUS;
      CH_EQ:    op = OP_EQUALS;
      default:  op = OP_NONE;
    endcase

    // Who letter decode.
    case (c)
      CH_U:    wb = WHO_USER;
      CH_G:    wb = WHO_GROUP;
      CH_O:    wb = WHO_OTHER;
      CH_A:    wb = WHO_ALL;
      default: wb = '0;
    endcase

    if (beat.func == FUNC_LOAD) begin
      s = begin_string(beat.start_mode);
    end else begin
      // Octal reading runs alongside the symbolic parse.
      if (c inside {[CH_ZERO:CH_SEVEN]}) begin
        s.octal_value = {s.octal_value[ModeW-4:0], c[2:0]};
      end else begin
        s.all_octal = 1'b0;
      end

      if (!s.error_seen) begin
        if (s.clause_phase == PH_WHO) begin
          if (wb != '0) begin
            s.who_mask = s.who_mask | wb;
          end else if (op != OP_NONE) begin
            if (s.who_mask == '0) begin
              s.who_mask = WHO_ALL;
            end
            s.pending_op   = op;
            s.work_mask    = '0;
            s.clause_phase = PH_OP;
          end else begin
            s.error_seen = 1'b1;
          end
        end else if (op != OP_NONE) begin
          s.working_mode = apply_op(s.pending_op, s.working_mode, s.who_mask, s.work_mask);
          s.work_mask    = '0;
          s.pending_op   = op;
          s.clause_phase = PH_OP;
        end else if (c == CH_COMMA) begin
          s.working_mode = apply_op(s.pending_op, s.working_mode, s.who_mask, s.work_mask);
          s.work_mask    = '0;
          s.pending_op   = OP_NONE;
          s.clause_phase = PH_WHO;
          s.who_mask     = '0;
        end else if (s.clause_phase == PH_COPY) begin
          s.error_seen = 1'b1;
        end else if (c == CH_R) begin
          s.work_mask    = s.work_mask | {3'b000, s.who_mask & READ_BITS};
          s.clause_phase = PH_PERM;
        end else if (c == CH_W) begin
          s.work_mask    = s.work_mask | {3'b000, s.who_mask & WRITE_BITS};
          s.clause_phase = PH_PERM;
        end else if (c == CH_X) begin
          s.work_mask    = s.work_mask | {3'b000, s.who_mask & EXEC_BITS};
          s.clause_phase = PH_PERM;
        end else if (c == CH_T) begin
          s.work_mask    = s.work_mask | STICKY_BIT;
          s.clause_phase = PH_PERM;
        end else if (s.clause_phase == PH_OP && (c == CH_U || c == CH_G || c == CH_O)) begin
          // Copy a class of the start mode into every named class.
          case (c)
            CH_U:    cls = s.original_mode[8:6];
            CH_G:    cls = s.original_mode[5:3];
            default: cls = s.original_mode[2:0];
          endcase
          s.work_mask    = {3'b000, s.who_mask & {cls, cls, cls}};
          s.clause_phase = PH_COPY;
        end else begin
          s.error_seen = 1'b1;
        end
      end

      // Last character closes the string and gives the result.
      if (beat.last) begin
        fire = 1'b1;
        if (s.all_octal) begin
          res.final_mode = s.octal_value;
          res.status     = ST_OK;
        end else if (s.error_seen || s.clause_phase == PH_WHO) begin
          res.final_mode = s.original_mode;
          res.status     = ST_ERROR;
        end else begin
          res.final_mode = apply_op(s.pending_op, s.working_mode, s.who_mask, s.work_mask);
          res.status     = ST_OK;
        end
        s = begin_string(s.original_mode);
      end
    end

    st_next = s;
  end

endmodule

`default_nettype wire

@@ design/smp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the symbolic mode parser.
module smp_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   item_valid,
  input wire                   item_stall,
  input wire smp_pkg::item_t   item,
  input wire                   result_valid,
  input wire                   result_stall,
  input wire smp_pkg::result_t result
);
  import smp_pkg::*;

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // The input side stalls only behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled while output could move");

  // A stalled input beat stays offered with the same payload.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_stall) |=> (item_valid && $stable(item)))
    else $error("input beat changed under stall");

  // A stalled result beat stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("result dropped under stall");

  // A stalled result beat keeps its payload.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(result))
    else $error("result changed under stall");

endmodule

bind symbolic_mode_parser smp_checker u_smp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

@@ sim/tb_symbolic_mode_parser.sv @@
`timescale 1ns / 1ps

module tb_symbolic_mode_parser;
  import smp_pkg::*;

  localparam int unsigned RandomBeats = 850;
  localparam int unsigned QuietFrom   = 800;

  // One queued input beat together with how the sender treats it.
  typedef struct {
    item_t       beat;
    int unsigned gap;
    bit          hold;
    bit          quiet;
  } feed_t;

  // Parse state of one mode string as the checker tracks it.
  typedef struct {
    logic [ModeW-1:0] base;
    logic [ModeW-1:0] edit;
    logic [ModeW-1:0] octal;
    bit               octal_only;
    logic [1:0]       phase;
    logic [WhoW-1:0]  who;
    logic [ModeW-1:0] chosen;
    logic [1:0]       op;
    bit               failed;
  } parse_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  feed_t       feed_q[$];
  result_t     final_mode_q[$];
  logic [7:0]  txt[$];
  parse_t      ps;
  result_t     want;
  bit          calm = 1'b0;
  bit          hold_next = 1'b0;
  int unsigned gap_pct = 0;
  int unsigned beats_made = 0;
  int unsigned strings_made = 0;
  int unsigned strings_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_results = 0;
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;

  symbolic_mode_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #6 clk = ~clk;

  // Clears the per-string state; the start mode is kept.
  function automatic void restart_string();
    ps.edit       = ps.base;
    ps.octal      = '0;
    ps.octal_only = 1'b1;
    ps.phase      = PH_WHO;
    ps.who        = '0;
    ps.chosen     = '0;
    ps.op         = OP_NONE;
    ps.failed     = 1'b0;
  endfunction

  // Folds the pending operator and its chosen bits into the edited mode.
  function automatic void commit_action();
    case (ps.op)
      OP_PLUS:   ps.edit = ps.edit | ps.chosen;
      OP_MINUS:  ps.edit = ps.edit & ~ps.chosen;
      OP_EQUALS: ps.edit = (ps.edit & ~{3'b000, ps.who}) | ps.chosen;
      default:   ;
    endcase
    ps.op     = OP_NONE;
    ps.chosen = '0;
  endfunction

  // Advances the parse by one character.
  function automatic void parse_char(logic [7:0] c);
    logic [1:0]      opc;
    logic [WhoW-1:0] wb;
    logic [2:0]      cls;
    case (c)
      CH_PLUS:  opc = OP_PLUS;
      CH_MINUS: opc = OP_MINUS;
      CH_EQ:    opc = OP_EQUALS;
      default:  opc = OP_NONE;
    endcase
    case (c)
      CH_U:    wb = WHO_USER;
      CH_G:    wb = WHO_GROUP;
      CH_O:    wb = WHO_OTHER;
      CH_A:    wb = WHO_ALL;
      default: wb = '0;
    endcase

    // The octal reading runs alongside the symbolic parse.
    if (c >= CH_ZERO && c <= CH_SEVEN) begin
      ps.octal = {ps.octal[ModeW-4:0], 3'(c - CH_ZERO)};
    end else begin
      ps.octal_only = 1'b0;
    end
    if (ps.failed) return;

    if (ps.phase == PH_WHO) begin
      if (wb != '0) begin
        ps.who |= wb;
      end else if (opc != OP_NONE) begin
        if (ps.who == '0) ps.who = WHO_ALL;
        ps.op     = opc;
        ps.chosen = '0;
        ps.phase  = PH_OP;
      end else begin
        ps.failed = 1'b1;
      end
      return;
    end

    if (opc != OP_NONE) begin
      commit_action();
      ps.op    = opc;
      ps.phase = PH_OP;
    end else if (c == CH_COMMA) begin
      commit_action();
      ps.phase = PH_WHO;
      ps.who   = '0;
    end else if (ps.phase == PH_COPY) begin
      ps.failed = 1'b1;
    end else if (c == CH_R) begin
      ps.chosen |= {3'b000, ps.who & READ_BITS};
      ps.phase = PH_PERM;
    end else if (c == CH_W) begin
      ps.chosen |= {3'b000, ps.who & WRITE_BITS};
      ps.phase = PH_PERM;
    end else if (c == CH_X) begin
      ps.chosen |= {3'b000, ps.who & EXEC_BITS};
      ps.phase = PH_PERM;
    end else if (c == CH_T) begin
      ps.chosen |= STICKY_BIT;
      ps.phase = PH_PERM;
    end else if (ps.phase == PH_OP && (c == CH_U || c == CH_G || c == CH_O)) begin
      // A copy letter always reads the start mode.
      cls = (c == CH_U) ? ps.base[8:6] : (c == CH_G) ? ps.base[5:3] : ps.base[2:0];
      ps.chosen = {3'b000, ps.who & {3{cls}}};
      ps.phase  = PH_COPY;
    end else begin
      ps.failed = 1'b1;
    end
  endfunction

  // Predicts the final mode for one accepted input beat.
  function automatic void update_mode_parse(item_t b);
    result_t r;
    if (b.func == FUNC_LOAD) begin
      ps.base = b.start_mode;
      restart_string();
      return;
    end
    parse_char(b.character);
    if (!b.last) return;
    if (ps.octal_only) begin
      r = '{final_mode: ps.octal, status: ST_OK};
    end else if (ps.failed || ps.phase == PH_WHO) begin
      r = '{final_mode: ps.base, status: ST_ERROR};
    end else begin
      commit_action();
      r = '{final_mode: ps.edit, status: ST_OK};
    end
    final_mode_q.push_back(r);
    restart_string();
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Queues one beat; idle gaps come in stretches whose density changes now and then.
  function automatic void push_beat(item_t b);
    feed_t f;
    if (beats_made % 40 == 0) begin
      case ($urandom_range(2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
    end
    f.beat  = b;
    f.hold  = hold_next;
    f.quiet = (beats_made >= QuietFrom);
    f.gap   = 0;
    if (!f.quiet && $urandom_range(99) < gap_pct) f.gap = $urandom_range(1, 10);
    hold_next = 1'b0;
    feed_q.push_back(f);
    beats_made++;
  endfunction

  function automatic void add_load(logic [ModeW-1:0] m);
    item_t b;
    b.func       = FUNC_LOAD;
    b.start_mode = m;
    b.character  = 8'($urandom_range(255));
    b.last       = 1'($urandom_range(1));
    push_beat(b);
  endfunction

  // Sends the collected characters as one string, last on the final beat.
  function automatic void send_text();
    item_t b;
    for (int i = 0; i < txt.size(); i++) begin
      b.func       = FUNC_CHAR;
      b.start_mode = 12'($urandom_range(4095));
      b.character  = txt[i];
      b.last       = (i == txt.size() - 1);
      push_beat(b);
    end
    txt.delete();
    strings_made++;
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_text();
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [ModeW-1:0] random_mode();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // One clause: optional who letters, then one or two actions.
  function automatic void add_clause();
    int unsigned k;
    if ($urandom_range(9) >= 3) begin
      repeat ($urandom_range(1, 3)) txt.push_back(pick("ugoa"));
    end
    repeat ($urandom_range(1, 2)) begin
      txt.push_back(pick("+-="));
      k = $urandom_range(9);
      if (k < 6) begin
        repeat ($urandom_range(1, 4)) txt.push_back(pick("rwxt"));
      end else if (k < 8) begin
        txt.push_back(pick("ugo"));
      end
    end
  endfunction

  // Mostly well-formed strings with random content; the rest are octal or broken.
  function automatic void add_random_string();
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    if ($urandom_range(9) < 6) add_load(random_mode());
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 5)) txt.push_back(8'(CH_ZERO + $urandom_range(7)));
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i != 0) txt.push_back(CH_COMMA);
        add_clause();
      end
      if (kind >= 80) begin
        pos = $urandom_range(txt.size() - 1);
        case ($urandom_range(3))
          0:       txt[pos] = 8'($urandom_range(255));
          1:       txt[pos] = pick("Xs0189,");
          2:       txt.insert(pos, pick("ugort"));
          default: txt = txt[0:pos];
        endcase
      end
    end
    send_text();
  endfunction

  // Sender: takes the next beat once the current one is accepted.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (feed_q.size() == 0) begin
        item_valid <= 1'b0;
      end else if (feed_q[0].gap != 0) begin
        feed_q[0].gap = feed_q[0].gap - 1;
        item_valid <= 1'b0;
      end else if (feed_q[0].hold && results_seen < strings_sent) begin
        item_valid <= 1'b0;
      end else begin
        item       <= feed_q[0].beat;
        calm       <= feed_q[0].quiet;
        item_valid <= 1'b1;
        if (feed_q[0].beat.func == FUNC_CHAR && feed_q[0].beat.last) strings_sent++;
        void'(feed_q.pop_front());
      end
    end
  end

  // Receiver: stalls in bursts between free-running stretches.
  always @(posedge clk) begin
    if (rst || calm) begin
      result_stall <= 1'b0;
      stall_left = 0;
      free_left  = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (free_left != 0) begin
      free_left--;
      result_stall <= 1'b0;
    end else if ($urandom_range(2) == 0) begin
      stall_left = $urandom_range(0, 9);
      free_left  = $urandom_range(0, 40);
      result_stall <= 1'b1;
    end else begin
      free_left = $urandom_range(0, 60);
      result_stall <= 1'b0;
    end
  end

  // Checker: compares each result beat, then predicts from the accepted input beat.
  always @(posedge clk) begin
    if (rst) begin
      ps.base = '0;
      restart_string();
    end else begin
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (result.status == ST_ERROR) error_results++;
        if (final_mode_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result: mode %o status %0d",
                                  result.final_mode, result.status));
        end else begin
          want = final_mode_q.pop_front();
          if (result.final_mode !== want.final_mode) begin
            note_mismatch($sformatf("final_mode: expected %o, got %o",
                                    want.final_mode, result.final_mode));
          end
          if (result.status !== want.status) begin
            note_mismatch($sformatf("status: expected %0d, got %0d",
                                    want.status, result.status));
          end
        end
      end
      if (item_valid && !item_stall) update_mode_parse(item);
    end
  end

  initial begin
    // Directed strings: reset start mode, load with a random last flag, bare equals, sticky,
    // copy from the start mode, rejected letters, octal overflow, missing operator,
    // unknown bytes and an empty clause.
    queue_text("7");
    add_load(12'o7777);
    queue_text("=");
    queue_text("-t");
    add_load(12'o0640);
    queue_text("u+x,o=u");
    queue_text("a+X");
    queue_text("12345");
    queue_text("u");
    txt.push_back(8'hFF);
    send_text();
    queue_text(",");

    while (beats_made < RandomBeats) begin
      if (strings_made == 30 || strings_made == 70) hold_next = 1'b1;
      add_random_string();
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (feed_q.size() != 0 || item_valid || final_mode_q.size() != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d beats in %0d mode strings; checked %0d results, %0d of them errors.",
             beats_made, strings_made, results_seen, error_results);
    if (mismatches == 0 && final_mode_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ symbolic_mode_parser.f @@
design/smp_pkg.sv
design/smp_step.sv
design/symbolic_mode_parser.sv
design/smp_checker.sv
sim/tb_symbolic_mode_parser.sv
